// ===== hdl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the character stream tokenizer: the
// transfer payloads, token and scan mode codes, and the token group that
// travels from the scanner to the token sequencer.
// ----------------------------------------------------------------------------
package cst_pkg;

   typedef enum logic [3:0] {
      TOK_NUMBER = 4'd0,
      TOK_IDENT  = 4'd1,
      TOK_PRINT  = 4'd2,
      TOK_PLUS   = 4'd3,
      TOK_MINUS  = 4'd4,
      TOK_STAR   = 4'd5,
      TOK_SLASH  = 4'd6,
      TOK_EQUAL  = 4'd7,
      TOK_SEMI   = 4'd8,
      TOK_LPAREN = 4'd9,
      TOK_RPAREN = 4'd10,
      TOK_EOF    = 4'd11,
      TOK_ERROR  = 4'd12
   } token_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_INT     = 3'd1,
      MODE_DOT     = 3'd2,
      MODE_FRAC    = 3'd3,
      MODE_IDENT   = 3'd4,
      MODE_SLASH   = 3'd5,
      MODE_COMMENT = 3'd6,
      MODE_DEAD    = 3'd7
   } scan_mode_type;

   typedef enum logic [2:0] {
      CLS_BLANK,
      CLS_NEWLINE,
      CLS_DIGIT,
      CLS_WORD,
      CLS_SLASH,
      CLS_DOT,
      CLS_OPERATOR,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic [7:0] character;
      logic       end_mark;
   } req_payload_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [15:0]    line_no;
      logic [7:0]     lexeme_length;
      logic [63:0]    mantissa;
      logic [7:0]     fraction_digits;
      logic           value_overflow;
      logic [7:0]     bad_character;
      logic           last_of_run;
   } rsp_payload_type;

   // Up to three tokens caused by one character, in emission order:
   // lexeme token, single-character token, end-of-file token.
   typedef struct packed {
      logic [15:0]    line_no;
      logic           lex_valid;
      token_kind_type lex_kind;
      logic [7:0]     lex_length;
      logic [63:0]    mantissa;
      logic [7:0]     fraction_digits;
      logic           value_overflow;
      logic           op_valid;
      token_kind_type op_kind;
      logic [7:0]     op_bad;
      logic           eof_valid;
   } group_type;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] KW_LENGTH = 3'd5;
   localparam logic [2:0] KW_FAIL   = 3'd7;

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_STAR       = 8'h2A;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_SEMI       = 8'h3B;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;

   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h70; // p
         3'd1:    c = 8'h72; // r
         3'd2:    c = 8'h69; // i
         3'd3:    c = 8'h6E; // n
         3'd4:    c = 8'h74; // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/cst_front.sv =====
// ----------------------------------------------------------------------------
// cst_front
// Scanner: classifies each transferred character, advances the scan mode,
// line counter and lexeme state, and pushes the group of tokens it
// completes into the token queue.
// ----------------------------------------------------------------------------
module cst_front #(
   parameter int LINE_WIDTH     = 16,
   parameter int MANTISSA_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_take,
   input  cst_pkg::req_payload_type in_data,
   output logic                     grp_push,
   output cst_pkg::group_type       grp_data
);
   import cst_pkg::*;

   scan_mode_type             mode_ff, mode_in;
   logic [LINE_WIDTH-1:0]     line_ff, line_in;
   logic [7:0]                len_ff, len_in;
   logic [MANTISSA_WIDTH-1:0] acc_ff, acc_in;
   logic [7:0]                frac_ff, frac_in;
   logic [2:0]                kw_ff, kw_in;
   logic                      ovf_ff, ovf_in;

   logic [7:0]                c;
   char_class_type            cls;
   logic [MANTISSA_WIDTH+3:0] scaled;
   logic                      acc_sat;
   logic [MANTISSA_WIDTH-1:0] acc_step;
   logic [LINE_WIDTH-1:0]     line_step;
   logic [LINE_WIDTH-1:0]     line_one;
   logic [2:0]                kw_step;
   logic                      run_fresh;
   token_kind_type            ident_kind;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type k;
      if (ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_CR) begin
         k = CLS_BLANK;
      end else if (ch == CHAR_NEWLINE) begin
         k = CLS_NEWLINE;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         k = CLS_DIGIT;
      end else if ((ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A)
                   || ch == CHAR_UNDERSCORE) begin
         k = CLS_WORD;
      end else if (ch == CHAR_SLASH) begin
         k = CLS_SLASH;
      end else if (ch == CHAR_DOT) begin
         k = CLS_DOT;
      end else if (ch == CHAR_PLUS || ch == CHAR_MINUS || ch == CHAR_STAR
                   || ch == CHAR_EQUAL || ch == CHAR_SEMI || ch == CHAR_LPAREN
                   || ch == CHAR_RPAREN) begin
         k = CLS_OPERATOR;
      end else begin
         k = CLS_OTHER;
      end
      return k;
   endfunction

   function automatic token_kind_type operator_kind(input logic [7:0] ch);
      token_kind_type k;
      case (ch)
         CHAR_PLUS:   k = TOK_PLUS;
         CHAR_MINUS:  k = TOK_MINUS;
         CHAR_STAR:   k = TOK_STAR;
         CHAR_EQUAL:  k = TOK_EQUAL;
         CHAR_SEMI:   k = TOK_SEMI;
         CHAR_LPAREN: k = TOK_LPAREN;
         default:     k = TOK_RPAREN;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v, input logic [1:0] d);
      logic [8:0] s;
      s = {1'b0, v} + {7'b0, d};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   assign c   = in_data.character;
   assign cls = classify(c);

   // acc * 10 + digit, saturated to the mantissa width
   assign scaled   = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + {{MANTISSA_WIDTH{1'b0}}, c[3:0]};
   assign acc_sat  = |scaled[MANTISSA_WIDTH+3:MANTISSA_WIDTH];
   assign acc_step = acc_sat ? {MANTISSA_WIDTH{1'b1}} : scaled[MANTISSA_WIDTH-1:0];

   assign line_one  = {{(LINE_WIDTH-1){1'b0}}, 1'b1};
   assign line_step = (line_ff == {LINE_WIDTH{1'b1}}) ? line_ff : line_ff + line_one;

   assign kw_step = (kw_ff < KW_LENGTH && c == keyword_char(kw_ff)) ? kw_ff + 3'd1 : KW_FAIL;

   assign ident_kind = (kw_ff == KW_LENGTH && len_ff == 8'd5) ? TOK_PRINT : TOK_IDENT;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= line_one;
         len_ff  <= '0;
         acc_ff  <= '0;
         frac_ff <= '0;
         kw_ff   <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         len_ff  <= len_in;
         acc_ff  <= acc_in;
         frac_ff <= frac_in;
         kw_ff   <= kw_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      len_in    = len_ff;
      acc_in    = acc_ff;
      frac_in   = frac_ff;
      kw_in     = kw_ff;
      ovf_in    = ovf_ff;
      run_fresh = 1'b0;

      grp_data                 = '0;
      grp_data.line_no         = 16'(line_ff);
      grp_data.lex_kind        = TOK_NUMBER;
      grp_data.lex_length      = len_ff;
      grp_data.mantissa        = 64'(acc_ff);
      grp_data.fraction_digits = frac_ff;
      grp_data.value_overflow  = ovf_ff;
      grp_data.op_kind         = TOK_ERROR;

      if (in_take) begin
         if (in_data.end_mark) begin
            unique case (mode_ff)
               MODE_INT, MODE_FRAC: begin
                  grp_data.lex_valid = 1'b1;
               end
               MODE_DOT: begin
                  grp_data.lex_valid = 1'b1;
                  grp_data.op_valid  = 1'b1;
                  grp_data.op_bad    = CHAR_DOT;
               end
               MODE_IDENT: begin
                  grp_data.lex_valid       = 1'b1;
                  grp_data.lex_kind        = ident_kind;
                  grp_data.mantissa        = '0;
                  grp_data.fraction_digits = '0;
                  grp_data.value_overflow  = 1'b0;
               end
               MODE_SLASH: begin
                  grp_data.op_valid = 1'b1;
                  grp_data.op_kind  = TOK_SLASH;
               end
               default: begin
               end
            endcase
            grp_data.eof_valid = 1'b1;
            mode_in = MODE_IDLE;
            line_in = line_one;
            len_in  = '0;
            acc_in  = '0;
            frac_in = '0;
            kw_in   = '0;
            ovf_in  = 1'b0;
         end else begin
            unique case (mode_ff)
               MODE_INT: begin
                  if (cls == CLS_DIGIT) begin
                     len_in = sat_inc(len_ff, 2'd1);
                     acc_in = acc_step;
                     ovf_in = ovf_ff | acc_sat;
                  end else if (cls == CLS_DOT) begin
                     mode_in = MODE_DOT;
                  end else begin
                     grp_data.lex_valid = 1'b1;
                     run_fresh = 1'b1;
                  end
               end
               MODE_DOT: begin
                  if (cls == CLS_DIGIT) begin
                     len_in  = sat_inc(len_ff, 2'd2);
                     acc_in  = acc_step;
                     ovf_in  = ovf_ff | acc_sat;
                     frac_in = 8'd1;
                     mode_in = MODE_FRAC;
                  end else begin
                     grp_data.lex_valid = 1'b1;
                     grp_data.op_valid  = 1'b1;
                     grp_data.op_bad    = CHAR_DOT;
                     mode_in = MODE_DEAD;
                  end
               end
               MODE_FRAC: begin
                  if (cls == CLS_DIGIT) begin
                     len_in  = sat_inc(len_ff, 2'd1);
                     frac_in = sat_inc(frac_ff, 2'd1);
                     acc_in  = acc_step;
                     ovf_in  = ovf_ff | acc_sat;
                  end else begin
                     grp_data.lex_valid = 1'b1;
                     run_fresh = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (cls == CLS_WORD || cls == CLS_DIGIT) begin
                     len_in = sat_inc(len_ff, 2'd1);
                     kw_in  = kw_step;
                  end else begin
                     grp_data.lex_valid       = 1'b1;
                     grp_data.lex_kind        = ident_kind;
                     grp_data.mantissa        = '0;
                     grp_data.fraction_digits = '0;
                     grp_data.value_overflow  = 1'b0;
                     run_fresh = 1'b1;
                  end
               end
               MODE_SLASH: begin
                  if (cls == CLS_SLASH) begin
                     mode_in = MODE_COMMENT;
                  end else begin
                     grp_data.lex_valid       = 1'b1;
                     grp_data.lex_kind        = TOK_SLASH;
                     grp_data.lex_length      = 8'd1;
                     grp_data.mantissa        = '0;
                     grp_data.fraction_digits = '0;
                     grp_data.value_overflow  = 1'b0;
                     run_fresh = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (cls == CLS_NEWLINE) begin
                     line_in = line_step;
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_DEAD: begin
               end
               default: begin
                  run_fresh = 1'b1;
               end
            endcase

            if (run_fresh) begin
               mode_in = MODE_IDLE;
               unique case (cls)
                  CLS_BLANK: begin
                  end
                  CLS_NEWLINE: begin
                     line_in = line_step;
                  end
                  CLS_DIGIT: begin
                     len_in  = 8'd1;
                     acc_in  = MANTISSA_WIDTH'(c[3:0]);
                     frac_in = '0;
                     kw_in   = '0;
                     ovf_in  = 1'b0;
                     mode_in = MODE_INT;
                  end
                  CLS_WORD: begin
                     len_in  = 8'd1;
                     acc_in  = '0;
                     frac_in = '0;
                     kw_in   = (c == keyword_char(3'd0)) ? 3'd1 : KW_FAIL;
                     ovf_in  = 1'b0;
                     mode_in = MODE_IDENT;
                  end
                  CLS_SLASH: begin
                     mode_in = MODE_SLASH;
                  end
                  CLS_OPERATOR: begin
                     grp_data.op_valid = 1'b1;
                     grp_data.op_kind  = operator_kind(c);
                  end
                  default: begin
                     grp_data.op_valid = 1'b1;
                     grp_data.op_bad   = c;
                     mode_in = MODE_DEAD;
                  end
               endcase
            end
         end
      end
   end

   assign grp_push = in_take & (grp_data.lex_valid | grp_data.op_valid | grp_data.eof_valid);

endmodule

// ===== hdl/cst_queue.sv =====
// ----------------------------------------------------------------------------
// cst_queue
// Short first-in first-out queue of token groups between the scanner and
// the token sequencer.
// ----------------------------------------------------------------------------
module cst_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cst_pkg::group_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cst_pkg::group_type head_data
);
   import cst_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   group_type        store_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CntFull);
   assign head_valid = (count_ff != '0);
   assign head_data  = store_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntFull)
      else $error("queue count beyond depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("group pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("group popped from an empty queue");

endmodule

// ===== hdl/cst_back.sv =====
// ----------------------------------------------------------------------------
// cst_back
// Token sequencer: takes token groups from the queue head and hands their
// tokens out one at a time through the result register, marking the last
// token of each group.
// ----------------------------------------------------------------------------
module cst_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  cst_pkg::group_type       head_data,
   output logic                     head_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output cst_pkg::rsp_payload_type rsp_data
);
   import cst_pkg::*;

   logic [2:0]      done_ff, done_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic [2:0]      pending;
   logic [2:0]      pick;
   logic            last;
   logic            load;

   assign pending = {head_data.eof_valid, head_data.op_valid, head_data.lex_valid} & ~done_ff;
   assign pick    = pending[0] ? 3'b001 : (pending[1] ? 3'b010 : 3'b100);
   assign last    = ((pending & ~pick) == 3'b000);
   assign load    = head_valid & (~out_valid_ff | rsp_pop);
   assign head_pop = load & last;

   always_comb begin
      done_in      = done_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      out_in       = out_ff;
      if (load) begin
         done_in      = last ? 3'b000 : (done_ff | pick);
         out_valid_in = 1'b1;
         out_in                 = '0;
         out_in.line_no         = head_data.line_no;
         out_in.last_of_run     = last;
         case (pick)
            3'b001: begin
               out_in.token_kind      = head_data.lex_kind;
               out_in.lexeme_length   = head_data.lex_length;
               out_in.mantissa        = head_data.mantissa;
               out_in.fraction_digits = head_data.fraction_digits;
               out_in.value_overflow  = head_data.value_overflow;
            end
            3'b010: begin
               out_in.token_kind    = head_data.op_kind;
               out_in.lexeme_length = 8'd1;
               out_in.bad_character = head_data.op_bad;
            end
            default: begin
               out_in.token_kind = TOK_EOF;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   a_done_partial: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) <= 2)
      else $error("all slots of a group marked done without pop");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (load && pick == 3'b100) |-> last)
      else $error("end-of-file token not last of its group");

   a_pending_on_load: assert property (@(posedge clock) disable iff (reset)
      load |-> (pending != 3'b000))
      else $error("group at queue head has no token left");

endmodule

// ===== hdl/char_stream_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// char_stream_tokenizer_core
// Streaming lexical analyzer: one ASCII character or end-of-input mark in,
// number, identifier, print, operator, end-of-file and error tokens out.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while req_full is low. The scanner
// updates its state in the cycle of the transfer and writes the tokens that
// character completes (zero to three) as one group into a four-entry queue.
// The token sequencer empties the queue into the result register one token
// per cycle while it is empty or popped. A token passes the queue and then
// the result register on its way to rsp_data. Input rate is one character
// per cycle as long as tokens are drained; output rate is one token per
// cycle while rsp_pop is high, and req_full rises when the queue holds four
// groups not yet handed out. Numbers saturate at 2^MANTISSA_WIDTH-1 with
// value_overflow set; line numbers saturate at 2^LINE_WIDTH-1. After an
// error token all characters are dropped until the end-of-input mark, which
// emits end-of-file and returns the block to its reset state.
module char_stream_tokenizer_core #(
   parameter int LINE_WIDTH     = 16,
   parameter int MANTISSA_WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  cst_pkg::req_payload_type req_data,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output cst_pkg::rsp_payload_type rsp_data
);
   import cst_pkg::*;

   logic      in_take;
   logic      grp_push;
   group_type grp_data;
   logic      head_valid;
   group_type head_data;
   logic      head_pop;

   assign in_take = req_push & ~req_full;

   cst_front #(
      .LINE_WIDTH     (LINE_WIDTH),
      .MANTISSA_WIDTH (MANTISSA_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_take  (in_take),
      .in_data  (req_data),
      .grp_push (grp_push),
      .grp_data (grp_data)
   );

   cst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .push_data  (grp_data),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   cst_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
